### hdl/teq_pkg.sv
`default_nettype none

package teq_pkg;

    // Fixed field widths of the request and result channels.
    localparam int OP_W     = 2;
    localparam int HANDLE_W = 4;
    localparam int DELAY_W  = 16;
    localparam int TAG_W    = 16;
    localparam int KIND_W   = 3;

    // Request operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;

    // Per-cycle strobes broadcast from the sequencer to every slot cell.
    typedef struct packed {
        logic insert;   // claim the lowest free slot
        logic cancel;   // free the addressed slot if active
        logic latch;    // capture overdue distance and due flag
        logic expire;   // retire the addressed slot after it won a search
    } cell_cmd_t;

endpackage

`default_nettype wire

### hdl/timer_expiry_queue.sv
// Timer expiry queue: a table of TIMER_SLOTS one-shot timers measured against a
// TIME_WIDTH-bit tick count that only tick requests advance; it is zero after reset.
// Requests arrive on the s_ channel (valid/ready): insert stores now plus a
// delay with a user tag in the lowest free slot, cancel frees a slot by handle,
// tick advances the count and retires every reached timer. Results leave on the
// m_ channel (valid/ready) with m_last set on the final result of a request.
// Insert and cancel present one result, passing through the execute and emit
// states into the output register with s_ready low; an unused op code gives no
// result. A tick walks a search wave down the row of slot cells, one cell per
// cycle; each wave finds one expiry, and a wave that finds none ends the tick,
// which holds s_ready low from start to end.
// Expiries leave earliest first, equal expiries lower slot first.
// One request is worked on at a time; s_ready is high whenever the sequencer
// is idle, even while the output register still holds a result. When the
// receiver stalls, the result waits in the output register and the sequencer
// holds until it can load the next one. Reset marks all slots free, zeroes the
// tick count and empties the output register; no clearing pass is needed.
`default_nettype none

module timer_expiry_queue #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [teq_pkg::OP_W-1:0]      s_op,
    input  wire [teq_pkg::HANDLE_W-1:0]  s_slot_handle,
    input  wire [teq_pkg::DELAY_W-1:0]   s_delay_ticks,
    input  wire [teq_pkg::TAG_W-1:0]     s_user_tag,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [teq_pkg::KIND_W-1:0]   m_kind,
    output logic [teq_pkg::HANDLE_W-1:0] m_handle_out,
    output logic [teq_pkg::TAG_W-1:0]    m_tag_out,
    output logic                         m_last
);

    localparam int SLOT_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam logic [CNT_W-1:0] WAVE_LEN = CNT_W'(TIMER_SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_LATCH = 5'b00100,
        ST_WAVE  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [TIME_WIDTH-1:0]          now_reg, now_next;
    logic [teq_pkg::OP_W-1:0]       op_reg;
    logic [teq_pkg::HANDLE_W-1:0]   handle_reg;
    logic [teq_pkg::DELAY_W-1:0]    delay_reg;
    logic [teq_pkg::TAG_W-1:0]      utag_reg;
    logic [teq_pkg::KIND_W-1:0]     res_kind_reg, res_kind_next;
    logic [teq_pkg::HANDLE_W-1:0]   res_handle_reg, res_handle_next;
    logic [teq_pkg::TAG_W-1:0]      res_tag_reg, res_tag_next;
    logic                           res_last_reg, res_last_next;
    logic                           held_valid_reg, held_valid_next;
    logic [SLOT_W-1:0]              held_idx_reg, held_idx_next;
    logic [teq_pkg::TAG_W-1:0]      held_tag_reg, held_tag_next;
    logic                           m_valid_reg, m_valid_next;
    logic [teq_pkg::KIND_W-1:0]     m_kind_reg, m_kind_next;
    logic [teq_pkg::HANDLE_W-1:0]   m_handle_reg, m_handle_next;
    logic [teq_pkg::TAG_W-1:0]      m_tag_reg, m_tag_next;
    logic                           m_last_reg, m_last_next;

    // Chain signals between neighboring cells; entry 0 feeds the first cell.
    logic                      claim      [0:TIMER_SLOTS];
    logic                      cand_valid [0:TIMER_SLOTS];
    logic [TIME_WIDTH-1:0]     cand_over  [0:TIMER_SLOTS];
    logic [SLOT_W-1:0]         cand_idx   [0:TIMER_SLOTS];
    logic [teq_pkg::TAG_W-1:0] cand_tag   [0:TIMER_SLOTS];
    logic [SLOT_W-1:0]         take_idx   [0:TIMER_SLOTS-1];
    logic [TIMER_SLOTS-1:0]    cancel_hits;

    teq_pkg::cell_cmd_t    cmd;
    logic [TIME_WIDTH-1:0] new_expiry;
    logic [SLOT_W-1:0]     target;
    logic [SLOT_W-1:0]     free_idx;
    logic                  table_full;
    logic                  any_cancel;
    logic                  handle_in_range;
    logic                  wave_done;
    logic                  win_valid;
    logic                  out_free;
    logic                  accept;

    assign accept          = s_valid && s_ready;
    assign s_ready         = (state_reg == ST_IDLE);
    assign out_free        = !m_valid_reg || m_ready;
    assign new_expiry      = now_reg + TIME_WIDTH'(delay_reg);
    assign handle_in_range = (32'(handle_reg) < 32'(TIMER_SLOTS));
    assign wave_done       = (state_reg == ST_WAVE) && (cnt_reg == WAVE_LEN);
    assign win_valid       = cand_valid[TIMER_SLOTS];
    assign table_full      = claim[TIMER_SLOTS];
    assign any_cancel      = |cancel_hits;

    // Broadcast strobes to the cells.
    assign cmd.insert = (state_reg == ST_EXEC) && (op_reg == teq_pkg::OP_INSERT);
    assign cmd.cancel = (state_reg == ST_EXEC) && (op_reg == teq_pkg::OP_CANCEL)
                        && handle_in_range;
    assign cmd.latch  = (state_reg == ST_LATCH);
    assign cmd.expire = wave_done && win_valid;
    assign target     = cmd.expire ? cand_idx[TIMER_SLOTS] : SLOT_W'(handle_reg);

    // Head of both chains: every slot before the first counts as active,
    // and the search starts with no candidate.
    assign claim[0]      = 1'b1;
    assign cand_valid[0] = 1'b0;
    assign cand_over[0]  = '0;
    assign cand_idx[0]   = '0;
    assign cand_tag[0]   = '0;

    // Row of slot cells.
    for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
        teq_cell #(
            .TIME_WIDTH (TIME_WIDTH),
            .SLOT_W     (SLOT_W),
            .SLOT_IDX   (i)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .cmd            (cmd),
            .now_count      (now_reg),
            .new_expiry     (new_expiry),
            .new_tag        (utag_reg),
            .target         (target),
            .claim_in       (claim[i]),
            .claim_out      (claim[i+1]),
            .take_idx       (take_idx[i]),
            .cancel_hit     (cancel_hits[i]),
            .cand_valid_in  (cand_valid[i]),
            .cand_over_in   (cand_over[i]),
            .cand_idx_in    (cand_idx[i]),
            .cand_tag_in    (cand_tag[i]),
            .cand_valid_out (cand_valid[i+1]),
            .cand_over_out  (cand_over[i+1]),
            .cand_idx_out   (cand_idx[i+1]),
            .cand_tag_out   (cand_tag[i+1])
        );
    end

    // At most one cell claims a slot, so its index is the OR of all claims.
    always_comb begin
        free_idx = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            free_idx = free_idx | take_idx[i];
        end
    end

    // Sequencer. A winner found at the end of a wave is held back until the
    // next wave shows whether another timer follows, which settles its last flag.
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        now_next        = now_reg;
        res_kind_next   = res_kind_reg;
        res_handle_next = res_handle_reg;
        res_tag_next    = res_tag_reg;
        res_last_next   = res_last_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        held_tag_next   = held_tag_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_handle_next   = m_handle_reg;
        m_tag_next      = m_tag_reg;
        m_last_next     = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_tag_next  = '0;
                res_last_next = 1'b1;
                case (op_reg)
                    teq_pkg::OP_INSERT: begin
                        res_kind_next   = table_full ? teq_pkg::KIND_FULL
                                                     : teq_pkg::KIND_QUEUED;
                        res_handle_next = table_full ? '0
                                                     : teq_pkg::HANDLE_W'(free_idx);
                        state_next      = ST_EMIT;
                    end
                    teq_pkg::OP_CANCEL: begin
                        res_kind_next   = any_cancel ? teq_pkg::KIND_CANCELLED
                                                     : teq_pkg::KIND_NOT_FOUND;
                        res_handle_next = handle_reg;
                        state_next      = ST_EMIT;
                    end
                    teq_pkg::OP_TICK: begin
                        now_next   = now_reg + TIME_WIDTH'(1);
                        state_next = ST_LATCH;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_LATCH: begin
                cnt_next   = '0;
                state_next = ST_WAVE;
            end
            ST_WAVE: begin
                if (wave_done) begin
                    cnt_next        = '0;
                    held_valid_next = win_valid;
                    if (win_valid) begin
                        held_idx_next = cand_idx[TIMER_SLOTS];
                        held_tag_next = cand_tag[TIMER_SLOTS];
                    end
                    if (held_valid_reg) begin
                        res_kind_next   = teq_pkg::KIND_EXPIRED;
                        res_handle_next = teq_pkg::HANDLE_W'(held_idx_reg);
                        res_tag_next    = held_tag_reg;
                        res_last_next   = !win_valid;
                        state_next      = ST_EMIT;
                    end else if (!win_valid) begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = res_kind_reg;
                    m_handle_next = res_handle_reg;
                    m_tag_next    = res_tag_reg;
                    m_last_next   = res_last_reg;
                    cnt_next      = '0;
                    state_next    = res_last_reg ? ST_IDLE : ST_WAVE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            now_reg        <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            now_reg        <= now_next;
            held_valid_reg <= held_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        if (accept) begin
            op_reg     <= s_op;
            handle_reg <= s_slot_handle;
            delay_reg  <= s_delay_ticks;
            utag_reg   <= s_user_tag;
        end
        res_kind_reg   <= res_kind_next;
        res_handle_reg <= res_handle_next;
        res_tag_reg    <= res_tag_next;
        res_last_reg   <= res_last_next;
        held_idx_reg   <= held_idx_next;
        held_tag_reg   <= held_tag_next;
        m_kind_reg     <= m_kind_next;
        m_handle_reg   <= m_handle_next;
        m_tag_reg      <= m_tag_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_handle_out = m_handle_reg;
    assign m_tag_out    = m_tag_reg;
    assign m_last       = m_last_reg;

endmodule

`default_nettype wire

### hdl/teq_cell.sv
`default_nettype none

module teq_cell #(
    parameter int TIME_WIDTH = 32,
    parameter int SLOT_W     = 4,
    parameter int SLOT_IDX   = 0
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  teq_pkg::cell_cmd_t         cmd,
    input  wire [TIME_WIDTH-1:0]       now_count,
    input  wire [TIME_WIDTH-1:0]       new_expiry,
    input  wire [teq_pkg::TAG_W-1:0]   new_tag,
    input  wire [SLOT_W-1:0]           target,
    // Free-slot claim chain: high while every earlier slot is active.
    input  wire                        claim_in,
    output logic                       claim_out,
    output logic [SLOT_W-1:0]          take_idx,
    output logic                       cancel_hit,
    // Best-candidate chain from the previous cell.
    input  wire                        cand_valid_in,
    input  wire [TIME_WIDTH-1:0]       cand_over_in,
    input  wire [SLOT_W-1:0]           cand_idx_in,
    input  wire [teq_pkg::TAG_W-1:0]   cand_tag_in,
    output logic                       cand_valid_out,
    output logic [TIME_WIDTH-1:0]      cand_over_out,
    output logic [SLOT_W-1:0]          cand_idx_out,
    output logic [teq_pkg::TAG_W-1:0]  cand_tag_out
);

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(SLOT_IDX);

    logic                      active_reg, active_next;
    logic                      pend_reg, pend_next;
    logic [TIME_WIDTH-1:0]     expiry_reg, expiry_next;
    logic [teq_pkg::TAG_W-1:0] tag_reg, tag_next;
    logic [TIME_WIDTH-1:0]     over_reg, over_next;
    logic                      cand_valid_reg, cand_valid_next;
    logic [TIME_WIDTH-1:0]     cand_over_reg, cand_over_next;
    logic [SLOT_W-1:0]         cand_idx_reg, cand_idx_next;
    logic [teq_pkg::TAG_W-1:0] cand_tag_reg, cand_tag_next;

    logic                  is_target;
    logic                  take;
    logic                  expire_hit;
    logic                  beats_in;
    logic [TIME_WIDTH-1:0] diff;

    assign is_target  = (target == MY_IDX);
    assign take       = cmd.insert && claim_in && !active_reg;
    assign claim_out  = claim_in && active_reg;
    assign take_idx   = take ? MY_IDX : '0;
    assign cancel_hit = cmd.cancel && is_target && active_reg;
    assign expire_hit = cmd.expire && is_target;
    assign diff       = now_count - expiry_reg;

    // This slot replaces the incoming candidate only when strictly more overdue,
    // so equal expiries keep the lower slot.
    assign beats_in = pend_reg && (!cand_valid_in || (over_reg > cand_over_in));

    // Slot contents and search stage.
    always_comb begin
        active_next     = active_reg;
        pend_next       = pend_reg;
        expiry_next     = expiry_reg;
        tag_next        = tag_reg;
        over_next       = over_reg;
        if (take) begin
            active_next = 1'b1;
            expiry_next = new_expiry;
            tag_next    = new_tag;
        end
        if (cancel_hit || expire_hit) begin
            active_next = 1'b0;
            pend_next   = 1'b0;
        end
        if (cmd.latch) begin
            over_next = diff;
            pend_next = active_reg && !diff[TIME_WIDTH-1];
        end
        if (beats_in) begin
            cand_valid_next = 1'b1;
            cand_over_next  = over_reg;
            cand_idx_next   = MY_IDX;
            cand_tag_next   = tag_reg;
        end else begin
            cand_valid_next = cand_valid_in;
            cand_over_next  = cand_over_in;
            cand_idx_next   = cand_idx_in;
            cand_tag_next   = cand_tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            pend_reg       <= 1'b0;
            cand_valid_reg <= 1'b0;
        end else begin
            active_reg     <= active_next;
            pend_reg       <= pend_next;
            cand_valid_reg <= cand_valid_next;
        end
        expiry_reg    <= expiry_next;
        tag_reg       <= tag_next;
        over_reg      <= over_next;
        cand_over_reg <= cand_over_next;
        cand_idx_reg  <= cand_idx_next;
        cand_tag_reg  <= cand_tag_next;
    end

    assign cand_valid_out = cand_valid_reg;
    assign cand_over_out  = cand_over_reg;
    assign cand_idx_out   = cand_idx_reg;
    assign cand_tag_out   = cand_tag_reg;

endmodule

`default_nettype wire

### hdl/teq_checker.sv
`default_nettype none

module teq_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_valid,
    input wire                          s_ready,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire [teq_pkg::KIND_W-1:0]    m_kind,
    input wire [teq_pkg::HANDLE_W-1:0]  m_handle_out,
    input wire [teq_pkg::TAG_W-1:0]     m_tag_out,
    input wire                          m_last
);

    // A stalled result keeps its contents until the transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_handle_out)
                                && $stable(m_tag_out) && $stable(m_last))
        else $error("result changed while stalled");

    // Only expiries carry a tag; every other result stands alone.
    a_tag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != teq_pkg::KIND_EXPIRED) |-> (m_tag_out == '0) && m_last)
        else $error("non-expiry result with tag or without last");

    // A table-full result carries handle zero.
    a_full_handle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == teq_pkg::KIND_FULL) |-> (m_handle_out == '0))
        else $error("table-full result with nonzero handle");

    // The block works on one request at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

endmodule

bind timer_expiry_queue teq_checker u_teq_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_handle_out (m_handle_out),
    .m_tag_out    (m_tag_out),
    .m_last       (m_last)
);

`default_nettype wire

### verif/timer_expiry_queue_tb.sv
`timescale 1ns / 100ps

module timer_expiry_queue_tb;
    import teq_pkg::*;

    localparam int SLOTS       = 16;
    localparam int TIME_W      = 32;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 400;
    localparam int RANDOM_OPS  = 360;
    localparam int QUIET_OPS   = 60;
    localparam int HOLD_CYCLES = 250;

    // The op code that the block has no use for.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    tag;
        logic                last;
    } timer_result_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_op;
    logic [HANDLE_W-1:0] s_slot_handle;
    logic [DELAY_W-1:0]  s_delay_ticks;
    logic [TAG_W-1:0]    s_user_tag;
    logic                m_valid;
    logic                m_ready;
    logic [KIND_W-1:0]   m_kind;
    logic [HANDLE_W-1:0] m_handle_out;
    logic [TAG_W-1:0]    m_tag_out;
    logic                m_last;

    // Shadow copy of the timer table and the tick count.
    logic [TIME_W-1:0] shadow_now;
    logic              shadow_active [SLOTS];
    logic [TIME_W-1:0] shadow_expiry [SLOTS];
    logic [TAG_W-1:0]  shadow_tag [SLOTS];

    timer_result_t awaited_results [$];
    timer_result_t oldest_result;

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    int  rx_stall_left = 0;
    bit  idle_en = 1'b1;

    timer_expiry_queue #(
        .TIMER_SLOTS(SLOTS),
        .TIME_WIDTH (TIME_W)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_slot_handle(s_slot_handle),
        .s_delay_ticks(s_delay_ticks),
        .s_user_tag   (s_user_tag),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_handle_out (m_handle_out),
        .m_tag_out    (m_tag_out),
        .m_last       (m_last)
    );

    always #6 aclk = ~aclk;

    // Works out the results of one accepted request and updates the shadow table.
    function automatic void predict_timer_op(input logic [OP_W-1:0] op,
                                             input logic [HANDLE_W-1:0] handle,
                                             input logic [DELAY_W-1:0] delay,
                                             input logic [TAG_W-1:0] tag);
        logic [TIME_W-1:0] lateness [SLOTS];
        logic              due [SLOTS];
        timer_result_t     res;
        int                best;
        int                total;
        int                free_slot;

        res = '0;
        res.last = 1'b1;
        if (op == OP_INSERT) begin
            free_slot = -1;
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (!shadow_active[i]) free_slot = i;
            end
            if (free_slot < 0) begin
                res.kind = KIND_FULL;
            end else begin
                shadow_active[free_slot] = 1'b1;
                shadow_expiry[free_slot] = shadow_now + TIME_W'(delay);
                shadow_tag[free_slot] = tag;
                res.kind = KIND_QUEUED;
                res.handle = HANDLE_W'(free_slot);
            end
            awaited_results.push_back(res);
        end else if (op == OP_CANCEL) begin
            res.handle = handle;
            if (shadow_active[handle]) begin
                shadow_active[handle] = 1'b0;
                res.kind = KIND_CANCELLED;
            end else begin
                res.kind = KIND_NOT_FOUND;
            end
            awaited_results.push_back(res);
        end else if (op == OP_TICK) begin
            // A timer is reached once now minus its expiry is not negative.
            shadow_now = shadow_now + 1'b1;
            total = 0;
            for (int i = 0; i < SLOTS; i++) begin
                lateness[i] = shadow_now - shadow_expiry[i];
                due[i] = shadow_active[i] && !lateness[i][TIME_W-1];
                if (due[i]) total++;
            end
            // Most overdue first; the strict compare keeps the lower slot on a tie.
            for (int k = 0; k < total; k++) begin
                best = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (due[i] && (best < 0 || lateness[i] > lateness[best])) best = i;
                end
                due[best] = 1'b0;
                shadow_active[best] = 1'b0;
                res.kind = KIND_EXPIRED;
                res.handle = HANDLE_W'(best);
                res.tag = shadow_tag[best];
                res.last = (k == total - 1);
                awaited_results.push_back(res);
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one request, with an optional gap first, and waits for its transfer.
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [HANDLE_W-1:0] handle,
                                input logic [DELAY_W-1:0] delay,
                                input logic [TAG_W-1:0] tag);
        int gap;

        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_slot_handle <= handle;
        s_delay_ticks <= delay;
        s_user_tag <= tag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_timer_op(op, handle, delay, tag);
    endtask

    // Stops offering requests until every awaited result has come back.
    task automatic pause_sender;
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    // Extremes of the fields, every op code and the ordering rules of a tick.
    task automatic test_basic_ops;
        send_request(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        send_request(OP_UNUSED, 4'hF, 16'hFFFF, 16'hFFFF);
        send_request(OP_CANCEL, 4'h0, 16'h0000, 16'h0000);
        send_request(OP_CANCEL, 4'hF, 16'hFFFF, 16'hFFFF);
        // A zero delay fires on the very next tick.
        send_request(OP_INSERT, 4'hF, 16'h0000, 16'hFFFF);
        send_request(OP_TICK, 4'h5, 16'h1234, 16'h4321);
        send_request(OP_INSERT, 4'h0, 16'hFFFF, 16'h0000);
        send_request(OP_CANCEL, 4'h0, 16'h0000, 16'h0000);
        send_request(OP_CANCEL, 4'h0, 16'h0000, 16'h0000);
        // The earliest expiry leaves first, then equal expiries by slot.
        send_request(OP_INSERT, 4'h0, 16'd1, 16'h1111);
        send_request(OP_INSERT, 4'h0, 16'd0, 16'h2222);
        send_request(OP_INSERT, 4'h0, 16'd1, 16'h3333);
        send_request(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        send_request(OP_INSERT, 4'hA, 16'd2, 16'hA5A5);
        send_request(OP_INSERT, 4'h5, 16'd3, 16'h5A5A);
        send_request(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        send_request(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        send_request(OP_TICK, 4'h0, 16'h0000, 16'h0000);
    endtask

    // Fills every slot, inserts into the full table, then frees the slots in random order.
    task automatic test_table_full;
        int order [SLOTS];
        int j;
        int swap;

        for (int i = 0; i < SLOTS; i++) begin
            send_request(OP_INSERT, HANDLE_W'($urandom_range(0, 15)),
                         DELAY_W'($urandom_range(100, 65535)),
                         TAG_W'($urandom_range(0, 65535)));
            order[i] = i;
        end
        send_request(OP_INSERT, 4'h0, 16'd0, 16'hFFFF);
        send_request(OP_INSERT, 4'hF, 16'hFFFF, 16'h0000);
        send_request(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        for (int i = SLOTS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            swap = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (int i = 0; i < SLOTS; i++) begin
            send_request(OP_CANCEL, HANDLE_W'(order[i]), DELAY_W'($urandom_range(0, 65535)),
                         TAG_W'($urandom_range(0, 65535)));
        end
        send_request(OP_CANCEL, HANDLE_W'(order[0]), 16'h0000, 16'h0000);
    endtask

    // The receiver holds off while requests keep coming, so the block stalls its input.
    task automatic test_backpressure;
        idle_en = 1'b0;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 6; i++) begin
            send_request(OP_INSERT, 4'h0, DELAY_W'($urandom_range(0, 2)),
                         TAG_W'($urandom_range(0, 65535)));
        end
        for (int i = 0; i < 4; i++) send_request(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        send_request(OP_CANCEL, 4'h0, 16'h0000, 16'h0000);
        send_request(OP_INSERT, 4'h0, 16'd0, 16'hBEEF);
        send_request(OP_TICK, 4'h0, 16'h0000, 16'h0000);
        send_request(OP_CANCEL, 4'h1, 16'h0000, 16'h0000);
        idle_en = 1'b1;
        pause_sender;
    endtask

    // Random mix biased toward short delays so that ticks keep retiring timers.
    task automatic test_random;
        int                  pick;
        int                  sel;
        int                  live [$];
        logic [OP_W-1:0]     op;
        logic [HANDLE_W-1:0] handle;
        logic [DELAY_W-1:0]  delay;
        logic [TAG_W-1:0]    tag;

        for (int n = 0; n < RANDOM_OPS; n++) begin
            // The closing stretch runs without idling on either side.
            if (n == RANDOM_OPS - QUIET_OPS) idle_en = 1'b0;
            pick = $urandom_range(0, 99);
            sel = $urandom_range(0, 99);
            handle = HANDLE_W'($urandom_range(0, 15));
            delay = DELAY_W'($urandom_range(0, 65535));
            tag = TAG_W'($urandom_range(0, 65535));
            if (pick < 35) begin
                op = OP_INSERT;
                if (sel < 70) delay = DELAY_W'($urandom_range(0, 6));
                else if (sel < 92) delay = DELAY_W'($urandom_range(7, 40));
            end else if (pick < 55) begin
                op = OP_CANCEL;
                live.delete();
                for (int i = 0; i < SLOTS; i++) begin
                    if (shadow_active[i]) live.push_back(i);
                end
                if (live.size() > 0 && sel < 80) begin
                    handle = HANDLE_W'(live[$urandom_range(0, live.size() - 1)]);
                end
            end else if (pick < 95) begin
                op = OP_TICK;
            end else begin
                op = OP_UNUSED;
            end
            send_request(op, handle, delay, tag);
            if (idle_en && $urandom_range(0, 39) == 0) pause_sender;
        end
        s_valid <= 1'b0;
    endtask

    // Result receiver: a long hold when asked, otherwise random stall bursts.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            rx_stall_left = $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each result transfer is checked against the oldest awaited result.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d handle %0d tag %h",
                                          m_kind, m_handle_out, m_tag_out));
            end else begin
                oldest_result = awaited_results[0];
                awaited_results.delete(0);
                if (m_kind !== oldest_result.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              m_kind, oldest_result.kind));
                if (m_handle_out !== oldest_result.handle)
                    report_mismatch($sformatf("handle %0d, expected %0d",
                                              m_handle_out, oldest_result.handle));
                if (m_tag_out !== oldest_result.tag)
                    report_mismatch($sformatf("tag %h, expected %h",
                                              m_tag_out, oldest_result.tag));
                if (m_last !== oldest_result.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              m_last, oldest_result.last));
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("** timer_expiry_queue: FAILED **");
            $finish;
        end
    end

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_INSERT;
        s_slot_handle = '0;
        s_delay_ticks = '0;
        s_user_tag = '0;
        m_ready = 1'b0;
        shadow_now = '0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_active[i] = 1'b0;
            shadow_expiry[i] = '0;
            shadow_tag[i] = '0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_ops;
        test_table_full;
        pause_sender;
        test_backpressure;
        test_random;

        // Let the last tick finish and catch any stray result.
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("** timer_expiry_queue: PASSED **");
        end else begin
            $display("** timer_expiry_queue: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/teq_pkg.sv
hdl/teq_cell.sv
hdl/timer_expiry_queue.sv
hdl/teq_checker.sv
verif/timer_expiry_queue_tb.sv
